[hdl/rotation_matrix_to_quaternion_core_macros.svh]
// assertion macros for the rotation matrix to quaternion core
// used by the checker; expects clk and rst in scope
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define RMQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/rmq_pkg.sv]
// shared constants, types and helpers for the rotation matrix to quaternion core
// no dependencies
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int DW        = 16;
  localparam int FRAC_BITS = 14;
  localparam int MW        = DW + 1;
  localparam int IN_W      = 9 * DW;
  localparam int OUT_W     = 4 * DW;
  localparam int USR_W     = 3;

  localparam logic [1:0] BR_W = 2'd0;
  localparam logic [1:0] BR_X = 2'd1;
  localparam logic [1:0] BR_Y = 2'd2;
  localparam logic [1:0] BR_Z = 2'd3;

  // sideband carried alongside the root pipeline
  typedef struct packed {
    logic [1:0]           idx;
    logic                 degen;
    logic signed [MW-1:0] da;
    logic signed [MW-1:0] db;
    logic signed [MW-1:0] dc;
  } sq_side_t;

  // apply sign and saturate a quotient magnitude to a signed word
  function automatic logic [DW-1:0] fix_sat(input logic neg, input logic ovf,
                                            input logic [DW-1:0] q);
    logic [DW-1:0] res;
    if (!neg) begin
      if (ovf || q[DW-1]) res = {1'b0, {(DW-1){1'b1}}};
      else res = q;
    end else begin
      if (ovf || (q > {1'b1, {(DW-1){1'b0}}})) res = {1'b1, {(DW-1){1'b0}}};
      else res = -q;
    end
    return res;
  endfunction

endpackage

[hdl/rmq_isqrt.sv]
// pipelined integer square root, one result bit per stage
// standalone; no package dependency
`timescale 1ns / 1ps

module rmq_isqrt #(
  parameter int RADW = 30
) (
  input  logic                clk,
  input  logic                en,
  input  logic [RADW-1:0]     rad,
  output logic [RADW/2-1:0]   root
);

  localparam int SQW = RADW / 2;
  localparam int RMW = SQW + 2;
  localparam int TRW = SQW + 4;

  logic [RADW-1:0] xs [1:SQW];
  logic [RMW-1:0]  rm [1:SQW];
  logic [SQW-1:0]  rt [1:SQW];

  for (genvar k = 1; k <= SQW; k++) begin : g_stage
    logic [RADW-1:0] x_in;
    logic [RMW-1:0]  r_in;
    logic [SQW-1:0]  q_in;
    logic [TRW-1:0]  sh;
    logic [TRW-1:0]  trial;
    logic            ge;

    if (k == 1) begin : g_first
      assign x_in = rad;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign x_in = xs[k-1];
      assign r_in = rm[k-1];
      assign q_in = rt[k-1];
    end

    assign sh    = {r_in, x_in[RADW-1 -: 2]};
    assign trial = {2'b00, q_in, 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k] <= x_in << 2;
        rm[k] <= ge ? RMW'(sh - trial) : RMW'(sh);
        rt[k] <= {q_in[SQW-2:0], ge};
      end
    end
  end

  assign root = rt[SQW];

endmodule

[hdl/rmq_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// standalone; no package dependency
`timescale 1ns / 1ps

module rmq_div #(
  parameter int NW   = 32,
  parameter int DENW = 17,
  parameter int QW   = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   num,
  input  logic [DENW-1:0] den,
  output logic [QW-1:0]   q,
  output logic            ovf
);

  localparam int HW  = NW - QW;
  localparam int CW  = ((HW > DENW) ? HW : DENW) + 1;
  localparam int RMW = DENW + 1;

  logic [RMW-1:0]  rm [0:QW];
  logic [QW-1:0]   lo [0:QW];
  logic [QW-1:0]   qq [0:QW];
  logic [DENW-1:0] dn [0:QW];
  logic            ov [0:QW];

  logic [CW-1:0] hi_ext;
  assign hi_ext = CW'(num[NW-1:QW]);

  // first stage: quotient would not fit in QW bits
  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= RMW'(hi_ext);
      lo[0] <= num[QW-1:0];
      qq[0] <= '0;
      dn[0] <= den;
      ov[0] <= (hi_ext >= CW'(den));
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [RMW:0] sh;
    logic [RMW:0] dx;
    logic         ge;

    assign sh = {rm[k-1], lo[k-1][QW-1]};
    assign dx = (RMW+1)'(dn[k-1]);
    assign ge = (sh >= dx);

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k] <= ge ? RMW'(sh - dx) : RMW'(sh);
        lo[k] <= lo[k-1] << 1;
        if (QW > 1) qq[k] <= {qq[k-1][QW-2:0], ge};
        else qq[k] <= QW'(ge);
        dn[k] <= dn[k-1];
        ov[k] <= ov[k-1];
      end
    end
  end

  assign q   = qq[QW];
  assign ovf = ov[QW];

endmodule

[hdl/rotation_matrix_to_quaternion_core.sv]
// rotation matrix to quaternion, Shepperd's method, fully pipelined
// depends on rmq_pkg, rmq_isqrt and rmq_div
`timescale 1ns / 1ps

// pipeline: stage 1, stage 2, the one-bit-per-stage root (RADW/2 stages), stage 3,
//   the divider (17 stages) and the output register lie between acceptance and m_tvalid
// throughput: one transaction per cycle; the whole pipe holds only while a result
//   sits on the output and m_tready is low
// reset: synchronous, clears the valid bits only; payload registers are not reset

module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2 (16 bits each)
  input  logic [rmq_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each)
  output logic [rmq_pkg::OUT_W-1:0]  m_tdata,
  // branch (2 bits), degenerate (1 bit)
  output logic [rmq_pkg::USR_W-1:0]  m_tuser
);

  import rmq_pkg::*;

  // widths that follow from the fraction width
  localparam int TW   = DW + 2;                                    // trace terms
  localparam int RW   = ((FRAC_BITS + 2 > TW) ? FRAC_BITS + 2 : TW) + 1;  // radicand
  localparam int RADW = 2 * ((RW - 1 + FRAC_BITS - 2 + 1) / 2);    // root input
  localparam int SQW  = RADW / 2;                                  // root output
  localparam int DENW = SQW + 2;                                   // 4 * root
  localparam int NW   = MW + FRAC_BITS + 1;                        // scaled numerator
  localparam int QW   = DW;
  localparam int L    = SQW + QW + 5;                              // valid stages

  localparam logic signed [RW-1:0] ONE_R = RW'(64'sd1 << FRAC_BITS);
  localparam logic [DW-1:0] ID_W = (FRAC_BITS >= DW - 1) ?
                                   {1'b0, {(DW-1){1'b1}}} : DW'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic [1:0]     idx;
    logic           degen;
    logic           sa;
    logic           sb;
    logic           sc;
    logic [SQW-1:0] big;
  } dv_side_t;

  // global advance: the pipe moves unless a result is waiting to be taken
  logic en;
  logic [L-1:0] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], s_tvalid};
    end
  end

  // ---------------- stage 1: trace terms and off-diagonal sums ----------------
  logic signed [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  assign m00 = s_tdata[0*DW +: DW];
  assign m01 = s_tdata[1*DW +: DW];
  assign m02 = s_tdata[2*DW +: DW];
  assign m10 = s_tdata[3*DW +: DW];
  assign m11 = s_tdata[4*DW +: DW];
  assign m12 = s_tdata[5*DW +: DW];
  assign m20 = s_tdata[6*DW +: DW];
  assign m21 = s_tdata[7*DW +: DW];
  assign m22 = s_tdata[8*DW +: DW];

  logic signed [TW-1:0] t0, t1, t2, t3;
  logic signed [MW-1:0] dyz, syz, dzx, szx, dxy, sxy;

  always_ff @(posedge clk) begin
    if (en) begin
      t0  <= TW'(m00) + TW'(m11) + TW'(m22);
      t1  <= TW'(m00) - TW'(m11) - TW'(m22);
      t2  <= TW'(m11) - TW'(m00) - TW'(m22);
      t3  <= TW'(m22) - TW'(m00) - TW'(m11);
      dyz <= MW'(m12) - MW'(m21);
      syz <= MW'(m12) + MW'(m21);
      dzx <= MW'(m20) - MW'(m02);
      szx <= MW'(m20) + MW'(m02);
      dxy <= MW'(m01) - MW'(m10);
      sxy <= MW'(m01) + MW'(m10);
    end
  end

  // ---------------- stage 2: largest term, radicand, operand routing ----------
  logic signed [TW-1:0] best;
  logic [1:0]           idx2;
  logic signed [RW-1:0] r2;
  logic                 degen2;
  logic [RADW-1:0]      rad2;
  sq_side_t             side2;

  always_comb begin
    // ties keep the earlier component
    best = t0;
    idx2 = BR_W;
    if (t1 > best) begin
      best = t1;
      idx2 = BR_X;
    end
    if (t2 > best) begin
      best = t2;
      idx2 = BR_Y;
    end
    if (t3 > best) begin
      best = t3;
      idx2 = BR_Z;
    end
    r2     = RW'(best) + ONE_R;
    degen2 = r2[RW-1] || (r2 == '0);
    // r * 2^(FRAC_BITS-2), so the root comes out as sqrt(r)/2 in fixed point
    rad2   = degen2 ? '0 : RADW'({r2[RW-2:0], {(FRAC_BITS-2){1'b0}}});

    side2.idx   = idx2;
    side2.degen = degen2;
    unique case (idx2)
      BR_W: begin
        side2.da = dyz; side2.db = dzx; side2.dc = dxy;
      end
      BR_X: begin
        side2.da = dyz; side2.db = sxy; side2.dc = szx;
      end
      BR_Y: begin
        side2.da = dzx; side2.db = sxy; side2.dc = syz;
      end
      default: begin
        side2.da = dxy; side2.db = szx; side2.dc = syz;
      end
    endcase
  end

  logic [RADW-1:0] rad;
  sq_side_t        sq_side [0:SQW];

  always_ff @(posedge clk) begin
    if (en) begin
      rad        <= rad2;
      sq_side[0] <= side2;
    end
  end

  for (genvar k = 1; k <= SQW; k++) begin : g_sq_side
    always_ff @(posedge clk) begin
      if (en) sq_side[k] <= sq_side[k-1];
    end
  end

  // ---------------- root pipeline ----------------
  logic [SQW-1:0] big;

  rmq_isqrt #(.RADW(RADW)) u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (big)
  );

  // ---------------- stage 3: magnitudes, rounded numerators, divisor ----------
  sq_side_t sq_end;
  logic [MW-1:0] mag_a, mag_b, mag_c;
  logic [NW-1:0] num_a3, num_b3, num_c3;
  logic [NW-1:0] half3;
  dv_side_t      side3;

  assign sq_end = sq_side[SQW];

  always_comb begin
    mag_a  = sq_end.da[MW-1] ? MW'(-sq_end.da) : MW'(sq_end.da);
    mag_b  = sq_end.db[MW-1] ? MW'(-sq_end.db) : MW'(sq_end.db);
    mag_c  = sq_end.dc[MW-1] ? MW'(-sq_end.dc) : MW'(sq_end.dc);
    // adding half the divisor turns the truncating divide into round half away
    half3  = NW'({big, 1'b0});
    num_a3 = (NW'(mag_a) << FRAC_BITS) + half3;
    num_b3 = (NW'(mag_b) << FRAC_BITS) + half3;
    num_c3 = (NW'(mag_c) << FRAC_BITS) + half3;

    side3.idx   = sq_end.idx;
    side3.degen = sq_end.degen || (big == '0);
    side3.sa    = sq_end.da[MW-1];
    side3.sb    = sq_end.db[MW-1];
    side3.sc    = sq_end.dc[MW-1];
    side3.big   = big;
  end

  logic [NW-1:0]   num_a, num_b, num_c;
  logic [DENW-1:0] den;
  dv_side_t        dv_side [0:QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      num_a      <= num_a3;
      num_b      <= num_b3;
      num_c      <= num_c3;
      den        <= {big, 2'b00};
      dv_side[0] <= side3;
    end
  end

  for (genvar k = 1; k <= QW + 1; k++) begin : g_dv_side
    always_ff @(posedge clk) begin
      if (en) dv_side[k] <= dv_side[k-1];
    end
  end

  // ---------------- three dividers in lockstep ----------------
  logic [QW-1:0] q_a, q_b, q_c;
  logic          ov_a, ov_b, ov_c;

  rmq_div #(.NW(NW), .DENW(DENW), .QW(QW)) u_div_a (
    .clk (clk), .en (en), .num (num_a), .den (den), .q (q_a), .ovf (ov_a)
  );

  rmq_div #(.NW(NW), .DENW(DENW), .QW(QW)) u_div_b (
    .clk (clk), .en (en), .num (num_b), .den (den), .q (q_b), .ovf (ov_b)
  );

  rmq_div #(.NW(NW), .DENW(DENW), .QW(QW)) u_div_c (
    .clk (clk), .en (en), .num (num_c), .den (den), .q (q_c), .ovf (ov_c)
  );

  // ---------------- final stage: saturate, place components ----------------
  dv_side_t      dv_end;
  logic [DW-1:0] fa, fb, fc, fbig;
  logic [DW-1:0] qw, qx, qy, qz;

  assign dv_end = dv_side[QW+1];

  always_comb begin
    fa = fix_sat(dv_end.sa, ov_a, q_a);
    fb = fix_sat(dv_end.sb, ov_b, q_b);
    fc = fix_sat(dv_end.sc, ov_c, q_c);
    // the root is non-negative; clamp only if it outgrows the word
    if ((SQW + 1)'(dv_end.big) > (SQW + 1)'({1'b0, {(DW-1){1'b1}}}))
      fbig = {1'b0, {(DW-1){1'b1}}};
    else
      fbig = DW'(dv_end.big);

    unique case (dv_end.idx)
      BR_W: begin
        qw = fbig; qx = fa; qy = fb; qz = fc;
      end
      BR_X: begin
        qw = fa; qx = fbig; qy = fb; qz = fc;
      end
      BR_Y: begin
        qw = fa; qx = fb; qy = fbig; qz = fc;
      end
      default: begin
        qw = fa; qx = fb; qy = fc; qz = fbig;
      end
    endcase

    // degenerate radicand: identity quaternion
    if (dv_end.degen) begin
      qw = ID_W;
      qx = '0;
      qy = '0;
      qz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {qz, qy, qx, qw};
      m_tuser <= {dv_end.degen, dv_end.idx};
    end
  end

endmodule

[hdl/rmq_checker.sv]
// port-level checks for the rotation matrix to quaternion core, bound to the top
// depends on rmq_pkg and rotation_matrix_to_quaternion_core_macros.svh
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_core_macros.svh"

module rmq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [rmq_pkg::OUT_W-1:0] m_tdata,
  input logic [rmq_pkg::USR_W-1:0] m_tuser
);

  import rmq_pkg::*;

  // a held result keeps its payload
  `RMQ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output transaction changed while stalled")

  // input side stalls exactly when a result is waiting
  `RMQ_ASSERT_SAME(a_ready, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")

  // degenerate results carry a zero vector part
  `RMQ_ASSERT_SAME(a_ident, m_tvalid && m_tuser[2], m_tdata[OUT_W-1:DW] == '0, "degenerate result is not the identity")

  // nothing comes out right after reset
  `RMQ_ASSERT_SAME(a_rst, $past(rst), !m_tvalid, "output valid right after reset")

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (.*);
